[hdl/fcpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package fcpc_pkg;

   localparam int FCPC_TEMP_W  = 8;
   localparam int FCPC_SPEED_W = 7;
   localparam int FCPC_HYST_W  = 8;
   localparam int FCPC_ADDR_W  = 5;
   localparam int FCPC_DATA_W  = 32;
   localparam int FCPC_PWM_SLOTS = 10;

   // Divider: magnitude of a speed difference over a breakpoint distance.
   localparam int FCPC_DIVISOR_W = 8;
   localparam int FCPC_STEPS     = FCPC_SPEED_W;
   localparam int FCPC_CNT_W     = $clog2(FCPC_STEPS + 1);

   typedef enum logic [2:0] {
      REG_TEMP_LOW   = 3'd0,
      REG_TEMP_MID   = 3'd1,
      REG_TEMP_HIGH  = 3'd2,
      REG_SPEED_LOW  = 3'd3,
      REG_SPEED_MID  = 3'd4,
      REG_SPEED_HIGH = 3'd5,
      REG_HYSTERESIS = 3'd6
   } fcpc_reg_type;

   localparam logic [FCPC_TEMP_W-1:0]  RST_TEMP_LOW   = 8'd40;
   localparam logic [FCPC_TEMP_W-1:0]  RST_TEMP_MID   = 8'd41;
   localparam logic [FCPC_TEMP_W-1:0]  RST_TEMP_HIGH  = 8'd70;
   localparam logic [FCPC_SPEED_W-1:0] RST_SPEED_LOW  = 7'd0;
   localparam logic [FCPC_SPEED_W-1:0] RST_SPEED_MID  = 7'd20;
   localparam logic [FCPC_SPEED_W-1:0] RST_SPEED_HIGH = 7'd100;
   localparam logic [FCPC_HYST_W-1:0]  RST_HYSTERESIS = 8'd1;

   typedef struct packed {
      logic signed [FCPC_TEMP_W-1:0] temp_low;
      logic signed [FCPC_TEMP_W-1:0] temp_mid;
      logic signed [FCPC_TEMP_W-1:0] temp_high;
      logic [FCPC_SPEED_W-1:0]       speed_low;
      logic [FCPC_SPEED_W-1:0]       speed_mid;
      logic [FCPC_SPEED_W-1:0]       speed_high;
      logic [FCPC_HYST_W-1:0]        hysteresis;
   } fcpc_cfg_type;

endpackage

[hdl/fcpc_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve configuration registers
// APB-style register file holding the curve breakpoints and the hysteresis.
// ----------------------------------------------------------------------------
module fcpc_csr
   import fcpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [FCPC_ADDR_W-1:0] csr_paddr,
   input  logic [FCPC_DATA_W-1:0] csr_pwdata,
   output logic [FCPC_DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output fcpc_cfg_type           cfg
);

   fcpc_cfg_type cfg_ff, cfg_in;
   fcpc_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel    = fcpc_reg_type'(csr_paddr[FCPC_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TEMP_LOW:   cfg_in.temp_low   = csr_pwdata[FCPC_TEMP_W-1:0];
            REG_TEMP_MID:   cfg_in.temp_mid   = csr_pwdata[FCPC_TEMP_W-1:0];
            REG_TEMP_HIGH:  cfg_in.temp_high  = csr_pwdata[FCPC_TEMP_W-1:0];
            REG_SPEED_LOW:  cfg_in.speed_low  = csr_pwdata[FCPC_SPEED_W-1:0];
            REG_SPEED_MID:  cfg_in.speed_mid  = csr_pwdata[FCPC_SPEED_W-1:0];
            REG_SPEED_HIGH: cfg_in.speed_high = csr_pwdata[FCPC_SPEED_W-1:0];
            REG_HYSTERESIS: cfg_in.hysteresis = csr_pwdata[FCPC_HYST_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TEMP_LOW:   csr_prdata = FCPC_DATA_W'(cfg_ff.temp_low);
         REG_TEMP_MID:   csr_prdata = FCPC_DATA_W'(cfg_ff.temp_mid);
         REG_TEMP_HIGH:  csr_prdata = FCPC_DATA_W'(cfg_ff.temp_high);
         REG_SPEED_LOW:  csr_prdata = FCPC_DATA_W'(cfg_ff.speed_low);
         REG_SPEED_MID:  csr_prdata = FCPC_DATA_W'(cfg_ff.speed_mid);
         REG_SPEED_HIGH: csr_prdata = FCPC_DATA_W'(cfg_ff.speed_high);
         REG_HYSTERESIS: csr_prdata = FCPC_DATA_W'(cfg_ff.hysteresis);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low   <= RST_TEMP_LOW;
         cfg_ff.temp_mid   <= RST_TEMP_MID;
         cfg_ff.temp_high  <= RST_TEMP_HIGH;
         cfg_ff.speed_low  <= RST_SPEED_LOW;
         cfg_ff.speed_mid  <= RST_SPEED_MID;
         cfg_ff.speed_high <= RST_SPEED_HIGH;
         cfg_ff.hysteresis <= RST_HYSTERESIS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/fcpc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve slope divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcpc_div
   import fcpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [FCPC_SPEED_W-1:0]   dividend,
   input  logic [FCPC_DIVISOR_W-1:0] divisor,
   output logic                      done,
   output logic [FCPC_SPEED_W-1:0]   quotient
);

   logic [FCPC_CNT_W-1:0]     count_ff, count_in;
   logic                      done_ff, done_in;
   logic [FCPC_DIVISOR_W-1:0] rem_ff, rem_in;
   logic [FCPC_DIVISOR_W-1:0] dsr_ff, dsr_in;
   // Dividend bits leave at the top while quotient bits enter at the bottom.
   logic [FCPC_SPEED_W-1:0]   quo_ff, quo_in;
   logic [FCPC_DIVISOR_W:0]   trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[FCPC_SPEED_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         count_in = FCPC_CNT_W'(FCPC_STEPS);
         rem_in   = '0;
         dsr_in   = divisor;
         quo_in   = dividend;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == FCPC_CNT_W'(1));
         rem_in   = fits ? FCPC_DIVISOR_W'(trial - {1'b0, dsr_ff})
                         : trial[FCPC_DIVISOR_W-1:0];
         quo_in   = {quo_ff[FCPC_SPEED_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/fcpc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve slope multiplier
// Bit-serial shift-and-add multiplier keeping the low speed-width bits.
// ----------------------------------------------------------------------------
module fcpc_mul
   import fcpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [FCPC_SPEED_W-1:0] multiplicand,
   input  logic [FCPC_SPEED_W-1:0] multiplier,
   output logic                    done,
   output logic [FCPC_SPEED_W-1:0] product
);

   logic [FCPC_CNT_W-1:0]   count_ff, count_in;
   logic                    done_ff, done_in;
   logic [FCPC_SPEED_W-1:0] mcand_ff, mcand_in;
   logic [FCPC_SPEED_W-1:0] mplier_ff, mplier_in;
   logic [FCPC_SPEED_W-1:0] acc_ff, acc_in;

   // Multiplier bits are taken most significant first; only the result
   // modulo two to the speed width is needed, so everything stays narrow.
   always_comb begin
      count_in  = count_ff;
      done_in   = 1'b0;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         count_in  = FCPC_CNT_W'(FCPC_STEPS);
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         acc_in    = '0;
      end else if (count_ff != '0) begin
         count_in  = count_ff - 1'b1;
         done_in   = (count_ff == FCPC_CNT_W'(1));
         acc_in    = {acc_ff[FCPC_SPEED_W-2:0], 1'b0}
                   + (mplier_ff[FCPC_SPEED_W-1] ? mcand_ff : '0);
         mplier_in = {mplier_ff[FCPC_SPEED_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[hdl/fan_curve_pwm_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller
// Three-point fan curve with hysteresis driving a slotted PWM line.
// ----------------------------------------------------------------------------
// Some items need no slope: a tick item, and a sample whose change stays
// within the hysteresis, lies below the first breakpoint, lies at or above the
// last one, or falls in no interval. Such an item's result is registered in
// the cycle after it is accepted, and the next item can follow right away
// while the receiver takes results. A sample that lands between two
// breakpoints runs the slope through a bit-serial divider and then a
// bit-serial multiplier: the divider's done starts the multiplier, and the
// multiplier's done registers the result. No item is taken until then. A
// finished result waits in the output register. The block takes the next item
// in the cycle the result leaves.
module fan_curve_pwm_controller_core
   import fcpc_pkg::*;
#(
   parameter int PWM_SLOTS = FCPC_PWM_SLOTS
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [FCPC_TEMP_W-1:0] req_temperature,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [FCPC_SPEED_W-1:0]       rsp_speed_pct,
   output logic                          rsp_pwm_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [FCPC_ADDR_W-1:0]        csr_paddr,
   input  logic [FCPC_DATA_W-1:0]        csr_pwdata,
   output logic [FCPC_DATA_W-1:0]        csr_prdata,
   output logic                          csr_pready
);

   localparam int SLOT_W  = $clog2(PWM_SLOTS);
   localparam int PROD_W  = 2 * SLOT_W;
   localparam int CMP_W   = (PROD_W > FCPC_SPEED_W) ? PROD_W : FCPC_SPEED_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_MUL  = 3'b100
   } state_type;

   fcpc_cfg_type cfg;

   state_type               state_ff, state_in;
   logic [FCPC_TEMP_W-1:0]  acc_temp_ff, acc_temp_in;
   logic [FCPC_SPEED_W-1:0] speed_ff, speed_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    level_ff, level_in;
   logic                    neg_ff, neg_in;
   logic [FCPC_SPEED_W-1:0] base_ff, base_in;
   logic [FCPC_SPEED_W-1:0] off_ff, off_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FCPC_SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                    rsp_pwm_ff, rsp_pwm_in;

   logic                          req_fire;
   logic signed [FCPC_TEMP_W-1:0] t_val, p_low, p_mid, p_high, p0_sel, p1_sel;
   logic [FCPC_TEMP_W:0]          diff, abs_diff;
   logic                          over, below, above, hit_low, hit_high;
   logic                          needs_calc;
   logic [FCPC_SPEED_W-1:0]       s0_sel, s1_sel, edge_speed;
   logic [FCPC_TEMP_W:0]          span;
   logic [FCPC_SPEED_W:0]         dspeed, dspeed_mag;
   logic [CMP_W-1:0]              slot_scaled;
   logic                          tick_level;

   logic                    div_start, div_done, mul_start, mul_done;
   logic [FCPC_SPEED_W-1:0] quotient, product, signed_prod, calc_speed;

   fcpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign t_val  = req_temperature;
   assign p_low  = cfg.temp_low;
   assign p_mid  = cfg.temp_mid;
   assign p_high = cfg.temp_high;

   // Distance from the held temperature (the last sample that left the band), as a nine-bit magnitude.
   assign diff     = {t_val[FCPC_TEMP_W-1], t_val} - {acc_temp_ff[FCPC_TEMP_W-1], acc_temp_ff};
   assign abs_diff = diff[FCPC_TEMP_W] ? (~diff + 1'b1) : diff;
   assign over     = abs_diff > {1'b0, cfg.hysteresis};

   assign below    = t_val < p_low;
   assign above    = t_val >= p_high;
   assign hit_low  = (t_val >= p_low) && (t_val < p_mid);
   assign hit_high = (t_val >= p_mid) && (t_val < p_high);

   // The upper interval wins when both hold.
   assign p0_sel = hit_high ? p_mid : p_low;
   assign p1_sel = hit_high ? p_high : p_mid;
   assign s0_sel = hit_high ? cfg.speed_mid : cfg.speed_low;
   assign s1_sel = hit_high ? cfg.speed_high : cfg.speed_mid;

   assign span       = {p1_sel[FCPC_TEMP_W-1], p1_sel} - {p0_sel[FCPC_TEMP_W-1], p0_sel};
   assign dspeed     = {1'b0, s1_sel} - {1'b0, s0_sel};
   assign dspeed_mag = dspeed[FCPC_SPEED_W] ? (~dspeed + 1'b1) : dspeed;

   assign needs_calc = over && !below && !above && (hit_low || hit_high);
   assign edge_speed = below ? cfg.speed_low : (above ? cfg.speed_high : speed_ff);

   assign slot_scaled = CMP_W'(slot_ff) * CMP_W'(PWM_SLOTS);
   assign tick_level  = slot_scaled <= CMP_W'(speed_ff);

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign div_start = req_fire && !req_mode && needs_calc;
   assign mul_start = (state_ff == ST_DIV) && div_done;

   fcpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dspeed_mag[FCPC_SPEED_W-1:0]),
      .divisor  (span[FCPC_DIVISOR_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   fcpc_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (off_ff),
      .multiplier   (quotient),
      .done         (mul_done),
      .product      (product)
   );

   assign signed_prod = neg_ff ? (FCPC_SPEED_W'(0) - product) : product;
   assign calc_speed  = base_ff + signed_prod;

   always_comb begin
      state_in     = state_ff;
      acc_temp_in  = acc_temp_ff;
      speed_in     = speed_ff;
      slot_in      = slot_ff;
      level_in     = level_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_speed_in = rsp_speed_ff;
      rsp_pwm_in   = rsp_pwm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode) begin
                  level_in     = tick_level;
                  slot_in      = (slot_ff == SLOT_W'(PWM_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_speed_in = speed_ff;
                  rsp_pwm_in   = tick_level;
               end else begin
                  slot_in = '0;
                  if (over) begin
                     acc_temp_in = t_val;
                  end
                  if (needs_calc) begin
                     state_in = ST_DIV;
                     neg_in   = dspeed[FCPC_SPEED_W];
                     base_in  = s0_sel;
                     off_in   = t_val[FCPC_SPEED_W-1:0] - p0_sel[FCPC_SPEED_W-1:0];
                  end else begin
                     if (over) begin
                        speed_in = edge_speed;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_speed_in = over ? edge_speed : speed_ff;
                     rsp_pwm_in   = level_ff;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in     = ST_IDLE;
               speed_in     = calc_speed;
               rsp_valid_in = 1'b1;
               rsp_speed_in = calc_speed;
               rsp_pwm_in   = level_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_temp_ff  <= '0;
         speed_ff     <= '0;
         slot_ff      <= '0;
         level_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_temp_ff  <= acc_temp_in;
         speed_ff     <= speed_in;
         slot_ff      <= slot_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff       <= neg_in;
      base_ff      <= base_in;
      off_ff       <= off_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_pwm_ff   <= rsp_pwm_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_pct = rsp_speed_ff;
   assign rsp_pwm_out   = rsp_pwm_ff;

endmodule

[hdl/fcpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fcpc_checker
   import fcpc_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [FCPC_SPEED_W-1:0]       rsp_speed_pct,
   input logic                          rsp_pwm_out
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_pct) && $stable(rsp_pwm_out))
   else $error("stalled result changed");

   // A tick item's result is valid in the cycle after it is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> rsp_valid)
   else $error("tick item result missing one cycle after accept");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
   else $error("result valid right after reset");

   // An item is taken only when the output stage can hold its result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
   else $error("item accepted while a result is stalled");

endmodule

bind fan_curve_pwm_controller_core fcpc_checker u_fcpc_checker (.*);

[tb/sv/fcpc_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller test package
// Item kinds shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package fcpc_tb_pkg;

   typedef enum logic {
      ITEM_SAMPLE = 1'b0,
      ITEM_TICK   = 1'b1
   } item_kind_type;

endpackage

[tb/sv/fan_curve_pwm_controller_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller checker
// Watches the item, result and register ports, predicts every result from its
// own model of the fan curve, hysteresis and slot counter, and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module fan_curve_pwm_controller_checker
   import fcpc_pkg::*;
   import fcpc_tb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [FCPC_TEMP_W-1:0] req_temperature,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [FCPC_SPEED_W-1:0]       rsp_speed_pct,
   input  logic                          rsp_pwm_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [FCPC_ADDR_W-1:0]        csr_paddr,
   input  logic [FCPC_DATA_W-1:0]        csr_pwdata,
   output int                            mismatch_count,
   output int                            pending_count
);

   typedef struct {
      logic [FCPC_SPEED_W-1:0] speed_pct;
      logic                    pwm_out;
   } fan_result_type;

   fan_result_type fan_results_q[$];

   int   curve_temp_low, curve_temp_mid, curve_temp_high;
   int   curve_speed_low, curve_speed_mid, curve_speed_high;
   int   hyst_band;
   int   held_temp, speed_now, slot_now;
   logic line_now;

   function automatic void apply_segment(input int t, input int p0, input int p1,
                                         input int s0, input int s1,
                                         inout int seg_speed, inout bit seg_hit);
      if (t >= p0 && t < p1) begin
         // Integer division in SystemVerilog truncates toward zero.
         seg_speed = s0 + ((s1 - s0) / (p1 - p0)) * (t - p0);
         seg_hit = 1'b1;
      end
   endfunction

   function automatic fan_result_type advance_fan(input item_kind_type kind, input int t);
      fan_result_type res;
      int             diff;
      int             seg_speed;
      bit             seg_hit;
      seg_speed = 0;
      seg_hit = 1'b0;
      if (kind == ITEM_SAMPLE) begin
         diff = t - held_temp;
         if (diff < 0)
            diff = -diff;
         if (diff > hyst_band) begin
            if (t < curve_temp_low) begin
               speed_now = curve_speed_low;
            end else if (t >= curve_temp_high) begin
               speed_now = curve_speed_high;
            end else begin
               apply_segment(t, curve_temp_low, curve_temp_mid,
                             curve_speed_low, curve_speed_mid, seg_speed, seg_hit);
               apply_segment(t, curve_temp_mid, curve_temp_high,
                             curve_speed_mid, curve_speed_high, seg_speed, seg_hit);
               if (seg_hit)
                  speed_now = seg_speed & 'h7F;
            end
            held_temp = t;
         end
         slot_now = 0;
      end else begin
         line_now = (slot_now <= speed_now / FCPC_PWM_SLOTS);
         slot_now = (slot_now + 1 >= FCPC_PWM_SLOTS) ? 0 : slot_now + 1;
      end
      res.speed_pct = speed_now[FCPC_SPEED_W-1:0];
      res.pwm_out = line_now;
      return res;
   endfunction

   always @(posedge clock) begin
      fan_result_type want;
      if (reset) begin
         curve_temp_low   = int'($signed(RST_TEMP_LOW));
         curve_temp_mid   = int'($signed(RST_TEMP_MID));
         curve_temp_high  = int'($signed(RST_TEMP_HIGH));
         curve_speed_low  = int'(RST_SPEED_LOW);
         curve_speed_mid  = int'(RST_SPEED_MID);
         curve_speed_high = int'(RST_SPEED_HIGH);
         hyst_band        = int'(RST_HYSTERESIS);
         held_temp = 0;
         speed_now = 0;
         slot_now = 0;
         line_now = 1'b1;
         fan_results_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (fcpc_reg_type'(csr_paddr[FCPC_ADDR_W-1:2]))
               REG_TEMP_LOW:   curve_temp_low   = int'($signed(csr_pwdata[7:0]));
               REG_TEMP_MID:   curve_temp_mid   = int'($signed(csr_pwdata[7:0]));
               REG_TEMP_HIGH:  curve_temp_high  = int'($signed(csr_pwdata[7:0]));
               REG_SPEED_LOW:  curve_speed_low  = int'(csr_pwdata[6:0]);
               REG_SPEED_MID:  curve_speed_mid  = int'(csr_pwdata[6:0]);
               REG_SPEED_HIGH: curve_speed_high = int'(csr_pwdata[6:0]);
               REG_HYSTERESIS: hyst_band        = int'(csr_pwdata[7:0]);
               default: ;
            endcase
         end
         // Results are retired before the new item is predicted, so a result
         // can never be matched against an item taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (fan_results_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no item outstanding, speed_pct %0d pwm_out %0d",
                        $time, rsp_speed_pct, rsp_pwm_out);
            end else begin
               want = fan_results_q.pop_front();
               if (rsp_speed_pct !== want.speed_pct) begin
                  mismatch_count++;
                  $display("%0t: speed_pct expected %0d, actual %0d",
                           $time, want.speed_pct, rsp_speed_pct);
               end
               if (rsp_pwm_out !== want.pwm_out) begin
                  mismatch_count++;
                  $display("%0t: pwm_out expected %0d, actual %0d",
                           $time, want.pwm_out, rsp_pwm_out);
               end
            end
         end
         if (req_valid && req_ready)
            fan_results_q.push_back(advance_fan(item_kind_type'(req_mode),
                                                int'(req_temperature)));
      end
      pending_count <= fan_results_q.size();
   end

endmodule

[tb/sv/fan_curve_pwm_controller_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve PWM controller testbench
// Drives directed and random samples and slot ticks through several fan curve
// settings with bursty input and a stalling output, and reports the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module fan_curve_pwm_controller_core_tb;
   import fcpc_pkg::*;
   import fcpc_tb_pkg::*;

   localparam int ITEMS_PER_SETTING = 235;
   localparam int STALL_LIMIT       = 2000;
   localparam int DRAIN_CYCLES      = 20;

   typedef enum logic [2:0] {
      SHAPE_TYPICAL,
      SHAPE_FULL_RANGE,
      SHAPE_UNORDERED,
      SHAPE_FROZEN,
      SHAPE_FALLING,
      SHAPE_OVERRANGE,
      SHAPE_RANDOM
   } curve_shape_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid;
   logic                          req_ready;
   logic                          req_mode;
   logic signed [FCPC_TEMP_W-1:0] req_temperature;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [FCPC_SPEED_W-1:0]       rsp_speed_pct;
   logic                          rsp_pwm_out;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [FCPC_ADDR_W-1:0]        csr_paddr;
   logic [FCPC_DATA_W-1:0]        csr_pwdata;
   logic [FCPC_DATA_W-1:0]        csr_prdata;
   logic                          csr_pready;

   int mismatch_count;
   int pending_count;

   fcpc_cfg_type curve;
   int           burst_left = 0;
   int           last_sample = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fan_curve_pwm_controller_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_pct   (rsp_speed_pct),
      .rsp_pwm_out     (rsp_pwm_out),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   fan_curve_pwm_controller_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_pct   (rsp_speed_pct),
      .rsp_pwm_out     (rsp_pwm_out),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   // The receiver picks a new stall style each time the seven-bit ready phase wraps.
   ready_style_type ready_style = READY_ALWAYS;
   logic [6:0]      ready_phase = '0;

   always @(posedge clock) begin
      ready_phase <= ready_phase + 1'b1;
      if (ready_phase == '0)
         ready_style <= ready_style_type'($urandom_range(0, 3));
      case (ready_style)
         READY_ALWAYS:  rsp_ready <= 1'b1;
         READY_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE:  rsp_ready <= ($urandom_range(0, 3) == 0);
         default:       rsp_ready <= (ready_phase[2:0] < 3'd5);
      endcase
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("** fan_curve_pwm_controller_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [7:0] clamp_temp(input int v);
      if (v < -128)
         return -8'sd128;
      if (v > 127)
         return 8'sd127;
      return 8'(v);
   endfunction

   task automatic send_item(input item_kind_type kind, input logic signed [7:0] t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid <= 1'b1;
      req_mode <= kind;
      req_temperature <= t;
      if (kind == ITEM_SAMPLE)
         last_sample = int'(t);
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic send_random_item();
      int lo, hi, near;
      logic signed [7:0] t;
      t = 8'($urandom);
      if ($urandom_range(0, 9) < 6) begin
         send_item(ITEM_TICK, t);
      end else begin
         case ($urandom_range(0, 3))
            0: ;
            1, 2: begin
               lo = int'($signed(curve.temp_low));
               hi = lo;
               if (int'($signed(curve.temp_mid)) < lo) lo = int'($signed(curve.temp_mid));
               if (int'($signed(curve.temp_high)) < lo) lo = int'($signed(curve.temp_high));
               if (int'($signed(curve.temp_mid)) > hi) hi = int'($signed(curve.temp_mid));
               if (int'($signed(curve.temp_high)) > hi) hi = int'($signed(curve.temp_high));
               lo = int'(clamp_temp(lo - 3));
               hi = int'(clamp_temp(hi + 3));
               t = clamp_temp(lo + int'($urandom_range(0, hi - lo)));
            end
            default: begin
               // Small steps around the last sample probe the hysteresis band.
               near = (curve.hysteresis > 6) ? 8 : int'(curve.hysteresis) + 2;
               t = clamp_temp(last_sample - near + int'($urandom_range(0, 2 * near)));
            end
         endcase
         send_item(ITEM_SAMPLE, t);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input fcpc_reg_type index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= FCPC_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic load_curve(input fcpc_cfg_type setting);
      wait_for_drain();
      write_reg(REG_TEMP_LOW,   32'($signed(setting.temp_low)));
      write_reg(REG_TEMP_MID,   32'($signed(setting.temp_mid)));
      write_reg(REG_TEMP_HIGH,  32'($signed(setting.temp_high)));
      write_reg(REG_SPEED_LOW,  32'(setting.speed_low));
      write_reg(REG_SPEED_MID,  32'(setting.speed_mid));
      write_reg(REG_SPEED_HIGH, 32'(setting.speed_high));
      write_reg(REG_HYSTERESIS, 32'(setting.hysteresis));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      curve = setting;
   endtask

   function automatic fcpc_cfg_type make_setting(input curve_shape_type shape);
      fcpc_cfg_type s;
      int a, b, c, swap;
      case (shape)
         SHAPE_TYPICAL:    s = '{25, 50, 85, 15, 45, 100, 2};
         SHAPE_FULL_RANGE: s = '{-128, 0, 127, 0, 100, 100, 0};
         // Middle point beyond the last one, so the first segment is long.
         SHAPE_UNORDERED:  s = '{10, 100, 40, 5, 90, 60, 1};
         // No change can exceed the band, so the speed never moves.
         SHAPE_FROZEN:     s = '{0, 10, 20, 30, 60, 90, 255};
         // Falling slopes that do not divide evenly check truncation toward zero.
         SHAPE_FALLING:    s = '{-40, -37, -20, 100, 60, 0, 0};
         SHAPE_OVERRANGE:  s = '{0, 5, 12, 3, 127, 101, 0};
         default: begin
            a = $urandom_range(0, 255) - 128;
            b = $urandom_range(0, 255) - 128;
            c = $urandom_range(0, 255) - 128;
            if ($urandom_range(0, 3) != 0) begin
               if (a > b) begin swap = a; a = b; b = swap; end
               if (b > c) begin swap = b; b = c; c = swap; end
               if (a > b) begin swap = a; a = b; b = swap; end
            end
            s.temp_low = 8'(a);
            s.temp_mid = 8'(b);
            s.temp_high = 8'(c);
            s.speed_low  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
            s.speed_mid  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
            s.speed_high = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
            s.hysteresis = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
         end
      endcase
      return s;
   endfunction

   curve_shape_type shape_plan[8] = '{SHAPE_TYPICAL, SHAPE_FULL_RANGE, SHAPE_UNORDERED,
                                      SHAPE_FROZEN, SHAPE_FALLING, SHAPE_OVERRANGE,
                                      SHAPE_RANDOM, SHAPE_RANDOM};

   initial begin
      req_valid <= 1'b0;
      req_mode <= ITEM_SAMPLE;
      req_temperature <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      curve = '{RST_TEMP_LOW, RST_TEMP_MID, RST_TEMP_HIGH, RST_SPEED_LOW,
                RST_SPEED_MID, RST_SPEED_HIGH, RST_HYSTERESIS};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset curve: speed zero still drives one slot
      // in ten high, then the ends of the curve, the band and both segments.
      send_item(ITEM_TICK, 8'sd0);
      send_item(ITEM_SAMPLE, 8'sd0);
      repeat (10) send_item(ITEM_TICK, -8'sd1);
      send_item(ITEM_SAMPLE, 8'sd127);
      repeat (3) send_item(ITEM_TICK, 8'sd0);
      send_item(ITEM_SAMPLE, -8'sd128);
      send_item(ITEM_SAMPLE, -8'sd127);
      send_item(ITEM_SAMPLE, -8'sd125);
      send_item(ITEM_SAMPLE, 8'sd40);
      send_item(ITEM_SAMPLE, 8'sd55);
      send_item(ITEM_SAMPLE, 8'sd56);
      repeat (2) send_item(ITEM_TICK, 8'sd0);
      send_item(ITEM_SAMPLE, 8'sd70);
      send_item(ITEM_SAMPLE, 8'sd67);
      send_item(ITEM_SAMPLE, 8'sd41);
      send_item(ITEM_TICK, 8'sd0);

      foreach (shape_plan[i]) begin
         load_curve(make_setting(shape_plan[i]));
         repeat (ITEMS_PER_SETTING) send_random_item();
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("** fan_curve_pwm_controller_core: PASSED **");
      else
         $display("** fan_curve_pwm_controller_core: FAILED **");
      $finish;
   end

endmodule
